FILE: hw/rtl/fpbp_pkg.sv
// shared types, constants and register codes of the framed packet byte parser
package fpbp_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_W         = 3;
    localparam int SLOT_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_MARKER     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_USER_LENGTH = 2'd2;

    localparam logic [7:0]  HEAD_MARKER_RST     = 8'd165;
    localparam logic [7:0]  END_MARKER_RST      = 8'd90;
    localparam logic [15:0] MAX_USER_LENGTH_RST = 16'd1024;
    localparam logic [15:0] MIN_USER_LENGTH     = 16'd2;
    localparam logic [15:0] CMD_BYTES           = 16'd2;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_GOOD    = 3'd1,
        ST_SUM_BAD = 3'd2,
        ST_LEN_BAD = 3'd3,
        ST_END_BAD = 3'd4
    } frame_status_t;

    typedef enum logic [7:0] {
        PH_HEAD = 8'b0000_0001,
        PH_CTRL = 8'b0000_0010,
        PH_SEQ  = 8'b0000_0100,
        PH_LEN  = 8'b0000_1000,
        PH_CMD  = 8'b0001_0000,
        PH_DATA = 8'b0010_0000,
        PH_SUM  = 8'b0100_0000,
        PH_END  = 8'b1000_0000
    } parse_phase_t;

    typedef struct packed {
        parse_phase_t phase;
        logic         half;
        logic [7:0]   sum;
        logic [15:0]  len;
        logic [15:0]  cnt;
        logic [7:0]   ctrl;
        logic [7:0]   seq;
        logic [15:0]  cmd;
    } chan_state_t;

    typedef struct packed {
        logic [7:0]    head_marker;
        logic [7:0]    end_marker;
        logic [15:0]   max_user_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0]    rx_byte;
        logic [CH_W-1:0] channel_id;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0] out_channel;
        logic          payload_valid;
        logic [7:0]    payload_byte;
        logic [15:0]   payload_index;
        logic [2:0]    frame_status;
        logic [7:0]    frame_control;
        logic [7:0]    frame_seq;
        logic [15:0]   frame_command;
        logic [15:0]   frame_user_length;
    } out_item_t;

    typedef struct packed {
        logic        we;
        logic [SLOT_W-1:0] slot;
        chan_state_t data;
    } state_wr_t;

endpackage

FILE: hw/rtl/fpbp_state.sv
// per-channel parse state store
module fpbp_state
    import fpbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] rd_slot,
    output chan_state_t       rd_data,
    input  state_wr_t         wr
);

    chan_state_t state_reg [NUM_CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                state_reg[i] <= '{phase: PH_HEAD, default: '0};
            end
        end
        else if (wr.we)
        begin
            state_reg[wr.slot] <= wr.data;
        end
    end

    assign rd_data = state_reg[rd_slot];

endmodule

FILE: hw/rtl/fpbp_step.sv
// next state and result of one byte on one channel
module fpbp_step
    import fpbp_pkg::*;
(
    input  cfg_t        cfg,
    input  in_item_t    item,
    input  logic        ch_ok,
    input  chan_state_t cur,
    output chan_state_t nxt,
    output out_item_t   res
);

    logic [7:0]    b;
    logic [15:0]   new_len;
    logic [16:0]   cnt_end;
    logic          pv;
    logic [15:0]   pidx;
    logic          cmd_known;
    frame_status_t status;

    assign b       = item.rx_byte;
    assign new_len = {b, cur.len[7:0]};
    assign cnt_end = {1'b0, cur.cnt} + 17'd3;

    always_comb
    begin
        nxt       = cur;
        pv        = 1'b0;
        pidx      = '0;
        cmd_known = 1'b1;
        status    = ST_NONE;
        unique case (cur.phase)
            PH_HEAD:
            begin
                if (b == cfg.head_marker)
                begin
                    nxt.sum   = b;
                    nxt.half  = 1'b0;
                    nxt.phase = PH_CTRL;
                end
            end
            PH_CTRL:
            begin
                nxt.ctrl  = b;
                nxt.sum   = cur.sum + b;
                nxt.phase = PH_SEQ;
            end
            PH_SEQ:
            begin
                nxt.seq   = b;
                nxt.sum   = cur.sum + b;
                nxt.phase = PH_LEN;
            end
            PH_LEN:
            begin
                nxt.sum = cur.sum + b;
                if (!cur.half)
                begin
                    nxt.len  = {8'd0, b};
                    nxt.half = 1'b1;
                end
                else
                begin
                    nxt.len  = new_len;
                    nxt.half = 1'b0;
                    if (new_len < MIN_USER_LENGTH || new_len > cfg.max_user_length)
                    begin
                        status    = ST_LEN_BAD;
                        cmd_known = 1'b0;
                        nxt.phase = PH_HEAD;
                    end
                    else
                    begin
                        nxt.phase = PH_CMD;
                    end
                end
            end
            PH_CMD:
            begin
                nxt.sum = cur.sum + b;
                if (!cur.half)
                begin
                    nxt.cmd  = {8'd0, b};
                    nxt.half = 1'b1;
                end
                else
                begin
                    nxt.cmd   = {b, cur.cmd[7:0]};
                    nxt.half  = 1'b0;
                    nxt.cnt   = '0;
                    nxt.phase = (cur.len > CMD_BYTES) ? PH_DATA : PH_SUM;
                end
            end
            PH_DATA:
            begin
                nxt.sum = cur.sum + b;
                pv      = 1'b1;
                pidx    = cur.cnt;
                nxt.cnt = cur.cnt + 16'd1;
                if (cnt_end >= {1'b0, cur.len})
                begin
                    nxt.phase = PH_SUM;
                end
            end
            PH_SUM:
            begin
                if (b == cur.sum)
                begin
                    nxt.phase = PH_END;
                end
                else
                begin
                    status    = ST_SUM_BAD;
                    nxt.phase = PH_HEAD;
                end
            end
            PH_END:
            begin
                status    = (b == cfg.end_marker) ? ST_GOOD : ST_END_BAD;
                nxt.phase = PH_HEAD;
            end
            default:
            begin
                nxt.phase = PH_HEAD;
            end
        endcase
    end

    always_comb
    begin
        res             = '0;
        res.out_channel = item.channel_id;
        if (ch_ok)
        begin
            res.payload_valid = pv;
            res.payload_byte  = pv ? b : 8'd0;
            res.payload_index = pidx;
            res.frame_status  = status;
            if (status != ST_NONE)
            begin
                res.frame_control     = nxt.ctrl;
                res.frame_seq         = nxt.seq;
                res.frame_command     = cmd_known ? nxt.cmd : 16'd0;
                res.frame_user_length = nxt.len;
            end
        end
    end

endmodule

FILE: hw/rtl/framed_packet_byte_parser_unit.sv
// Framed packet byte parser: one received byte per item, tagged with a channel; each
// channel keeps its own parse phase through head marker, control, sequence, 16-bit
// little-endian length, 16-bit command, payload, additive checksum and end marker.
// Every item gives exactly one result item: payload bytes come out with their index and
// the last byte of a frame carries its status (good, checksum bad, length bad, end
// marker bad) with control, sequence, command and length. An item passes through the
// input register and then the result register; a new item is taken every cycle unless
// the output stalls, including back to back on the same channel, since the per-channel
// state is read and written in the same cycle. The user must write configuration
// through cfg_we/cfg_index/cfg_data only while no item is in flight (not enforced).
module framed_packet_byte_parser_unit
    import fpbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t        cfg_reg;
    logic        in_vld_reg;
    in_item_t    in_item_reg;
    logic        out_vld_reg;
    out_item_t   out_item_reg;

    logic        advance;
    logic        in_take;
    logic        ch_ok;
    logic [SLOT_W-1:0] slot;
    chan_state_t cur_state;
    chan_state_t nxt_state;
    out_item_t   res;
    state_wr_t   st_wr;

    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_vld_reg;
    assign out_data  = out_item_reg;

    assign ch_ok = int'(in_item_reg.channel_id) < NUM_CHANNELS;
    assign slot  = SLOT_W'(in_item_reg.channel_id);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.head_marker     <= HEAD_MARKER_RST;
            cfg_reg.end_marker      <= END_MARKER_RST;
            cfg_reg.max_user_length <= MAX_USER_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEAD_MARKER:     cfg_reg.head_marker     <= cfg_data[7:0];
                CFG_END_MARKER:      cfg_reg.end_marker      <= cfg_data[7:0];
                CFG_MAX_USER_LENGTH: cfg_reg.max_user_length <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= res;
        end
    end

    assign st_wr.we   = advance && ch_ok;
    assign st_wr.slot = slot;
    assign st_wr.data = nxt_state;

    fpbp_state u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_slot (slot),
        .rd_data (cur_state),
        .wr      (st_wr)
    );

    fpbp_step u_step (
        .cfg   (cfg_reg),
        .item  (in_item_reg),
        .ch_ok (ch_ok),
        .cur   (cur_state),
        .nxt   (nxt_state),
        .res   (res)
    );

endmodule

FILE: tb/tb_top.sv
// testbench for the framed packet byte parser: per-channel frames against a byte-level predictor
`timescale 1ns / 1ps

module tb_top;
    import fpbp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {FR_GOOD, FR_SUM_BAD, FR_END_BAD, FR_LEN_BAD} frame_kind_t;

    class parser_scoreboard;
        logic [7:0]   head_mk;
        logic [7:0]   end_mk;
        logic [15:0]  max_len;
        parse_phase_t phase [NUM_CHANNELS];
        logic         half_seen [NUM_CHANNELS];
        logic [7:0]   run_sum [NUM_CHANNELS];
        logic [15:0]  len_w [NUM_CHANNELS];
        logic [15:0]  pay_cnt [NUM_CHANNELS];
        logic [7:0]   ctrl_b [NUM_CHANNELS];
        logic [7:0]   seq_b [NUM_CHANNELS];
        logic [15:0]  cmd_w [NUM_CHANNELS];
        out_item_t    parse_results_q [$];
        int           errors;

        function new();
            int i;
            head_mk = HEAD_MARKER_RST;
            end_mk  = END_MARKER_RST;
            max_len = MAX_USER_LENGTH_RST;
            for (i = 0; i < NUM_CHANNELS; i++)
            begin
                phase[i]     = PH_HEAD;
                half_seen[i] = 1'b0;
                run_sum[i]   = '0;
                len_w[i]     = '0;
                pay_cnt[i]   = '0;
                ctrl_b[i]    = '0;
                seq_b[i]     = '0;
                cmd_w[i]     = '0;
            end
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_HEAD_MARKER:     head_mk = val[7:0];
                CFG_END_MARKER:      end_mk  = val[7:0];
                CFG_MAX_USER_LENGTH: max_len = val[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return parse_results_q.size();
        endfunction

        function void note_rx_byte(in_item_t it);
            out_item_t     r;
            frame_status_t st;
            logic [7:0]    b;
            int            ch;
            bit            cmd_seen;
            r        = '0;
            st       = ST_NONE;
            cmd_seen = 1'b1;
            b        = it.rx_byte;
            ch       = int'(it.channel_id);
            r.out_channel = it.channel_id;
            if (ch >= NUM_CHANNELS)
            begin
                parse_results_q.push_back(r);
                return;
            end
            case (phase[ch])
                PH_HEAD:
                begin
                    if (b == head_mk)
                    begin
                        run_sum[ch]   = b;
                        half_seen[ch] = 1'b0;
                        phase[ch]     = PH_CTRL;
                    end
                end
                PH_CTRL:
                begin
                    ctrl_b[ch]  = b;
                    run_sum[ch] = run_sum[ch] + b;
                    phase[ch]   = PH_SEQ;
                end
                PH_SEQ:
                begin
                    seq_b[ch]   = b;
                    run_sum[ch] = run_sum[ch] + b;
                    phase[ch]   = PH_LEN;
                end
                PH_LEN:
                begin
                    run_sum[ch] = run_sum[ch] + b;
                    if (!half_seen[ch])
                    begin
                        len_w[ch]     = {8'h00, b};
                        half_seen[ch] = 1'b1;
                    end
                    else
                    begin
                        len_w[ch][15:8] = b;
                        half_seen[ch]   = 1'b0;
                        if (len_w[ch] < MIN_USER_LENGTH || len_w[ch] > max_len)
                        begin
                            st        = ST_LEN_BAD;
                            cmd_seen  = 1'b0;
                            phase[ch] = PH_HEAD;
                        end
                        else
                            phase[ch] = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    run_sum[ch] = run_sum[ch] + b;
                    if (!half_seen[ch])
                    begin
                        cmd_w[ch]     = {8'h00, b};
                        half_seen[ch] = 1'b1;
                    end
                    else
                    begin
                        cmd_w[ch][15:8] = b;
                        half_seen[ch]   = 1'b0;
                        pay_cnt[ch]     = '0;
                        phase[ch]       = (len_w[ch] > CMD_BYTES) ? PH_DATA : PH_SUM;
                    end
                end
                PH_DATA:
                begin
                    run_sum[ch]     = run_sum[ch] + b;
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    r.payload_index = pay_cnt[ch];
                    pay_cnt[ch]     = pay_cnt[ch] + 16'd1;
                    if (32'(pay_cnt[ch]) + 32'(CMD_BYTES) >= 32'(len_w[ch]))
                        phase[ch] = PH_SUM;
                end
                PH_SUM:
                begin
                    if (b == run_sum[ch])
                        phase[ch] = PH_END;
                    else
                    begin
                        st        = ST_SUM_BAD;
                        phase[ch] = PH_HEAD;
                    end
                end
                default:
                begin
                    st        = (b == end_mk) ? ST_GOOD : ST_END_BAD;
                    phase[ch] = PH_HEAD;
                end
            endcase
            r.frame_status = st;
            if (st != ST_NONE)
            begin
                r.frame_control     = ctrl_b[ch];
                r.frame_seq         = seq_b[ch];
                r.frame_command     = cmd_seen ? cmd_w[ch] : 16'h0000;
                r.frame_user_length = len_w[ch];
            end
            parse_results_q.push_back(r);
        endfunction

        function void field_check(string name, logic [15:0] exp_v, logic [15:0] got_v);
            if (exp_v !== got_v)
            begin
                $error("%s expected %0d got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_parse_result(out_item_t got);
            out_item_t e;
            if (parse_results_q.size() == 0)
            begin
                $error("result on channel %0d with none expected", got.out_channel);
                errors++;
                return;
            end
            e = parse_results_q.pop_front();
            field_check("out_channel", 16'(e.out_channel), 16'(got.out_channel));
            field_check("payload_valid", 16'(e.payload_valid), 16'(got.payload_valid));
            field_check("payload_byte", 16'(e.payload_byte), 16'(got.payload_byte));
            field_check("payload_index", e.payload_index, got.payload_index);
            field_check("frame_status", 16'(e.frame_status), 16'(got.frame_status));
            field_check("frame_control", 16'(e.frame_control), 16'(got.frame_control));
            field_check("frame_seq", 16'(e.frame_seq), 16'(got.frame_seq));
            field_check("frame_command", e.frame_command, got.frame_command);
            field_check("frame_user_length", e.frame_user_length, got.frame_user_length);
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    parser_scoreboard sb;
    in_item_t         stim_q [$];
    logic [7:0]       frame_buf [$];
    logic [7:0]       chan_q [NUM_CHANNELS][$];
    int               chan_noise [NUM_CHANNELS];
    logic [7:0]       cur_head = HEAD_MARKER_RST;
    logic [7:0]       cur_end  = END_MARKER_RST;
    int               cur_max  = int'(MAX_USER_LENGTH_RST);
    bit               hold_req = 1'b0;

    framed_packet_byte_parser_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_rx_byte(in_data);
            if (out_valid && !out_stall)
                sb.check_parse_result(out_data);
        end
    end

    function automatic void queue_byte(logic [7:0] b, int ch);
        in_item_t it;
        it.rx_byte    = b;
        it.channel_id = CH_W'(ch);
        stim_q.push_back(it);
    endfunction

    function automatic void build_frame(frame_kind_t kind, logic [7:0] ctrl_v, logic [7:0] seq_v,
                                        logic [15:0] cmd_v, logic [15:0] len_v);
        logic [7:0] csum;
        int         i;
        frame_buf.delete();
        frame_buf.push_back(cur_head);
        frame_buf.push_back(ctrl_v);
        frame_buf.push_back(seq_v);
        frame_buf.push_back(len_v[7:0]);
        frame_buf.push_back(len_v[15:8]);
        if (kind == FR_LEN_BAD)
            return;
        frame_buf.push_back(cmd_v[7:0]);
        frame_buf.push_back(cmd_v[15:8]);
        for (i = 0; i < int'(len_v) - 2; i++)
            frame_buf.push_back(8'($urandom));
        csum = '0;
        for (i = 0; i < frame_buf.size(); i++)
            csum = csum + frame_buf[i];
        if (kind == FR_SUM_BAD)
        begin
            frame_buf.push_back(csum + 8'($urandom_range(1, 255)));
            return;
        end
        frame_buf.push_back(csum);
        if (kind == FR_END_BAD)
            frame_buf.push_back(cur_end ^ 8'($urandom_range(1, 255)));
        else
            frame_buf.push_back(cur_end);
    endfunction

    function automatic void queue_frame(int ch);
        int i;
        for (i = 0; i < frame_buf.size(); i++)
            queue_byte(frame_buf[i], ch);
    endfunction

    function automatic void plan_channel_traffic(int ch);
        int          sel;
        int          k;
        int          lim;
        int          plen;
        int          len_v;
        logic [7:0]  b;
        frame_kind_t kind;
        sel = $urandom_range(0, 99);
        if (sel < 8)
        begin
            k = $urandom_range(1, 3);
            repeat (k)
            begin
                do
                    b = 8'($urandom);
                while (b == cur_head);
                chan_q[ch].push_back(b);
            end
            chan_noise[ch] = k;
            return;
        end
        kind = (sel < 60) ? FR_GOOD : (sel < 72) ? FR_SUM_BAD : (sel < 84) ? FR_END_BAD
             : FR_LEN_BAD;
        if (kind == FR_LEN_BAD)
        begin
            if (cur_max >= 65535 || $urandom_range(0, 2) == 0)
                len_v = $urandom_range(0, 1);
            else if ($urandom_range(0, 1) == 0)
                len_v = cur_max + 1;
            else
                len_v = $urandom_range(cur_max + 1, 65535);
        end
        else
        begin
            lim = cur_max - 2;
            sel = $urandom_range(0, 99);
            if (sel < 3)
                plen = $urandom_range(0, (lim < 700) ? lim : 700);
            else if (sel < 5 && lim <= 1100)
                plen = lim;
            else
                plen = $urandom_range(0, (lim < 12) ? lim : 12);
            len_v = plen + 2;
        end
        build_frame(kind, 8'($urandom), 8'($urandom), 16'($urandom), 16'(len_v));
        foreach (frame_buf[i])
            chan_q[ch].push_back(frame_buf[i]);
        chan_noise[ch] = 0;
    endfunction

    function automatic void mix_channel_traffic(int n_items);
        int counted;
        int ch;
        int run;
        int i;
        counted = 0;
        ch      = 0;
        run     = 0;
        while (counted < n_items)
        begin
            if (run == 0)
            begin
                ch  = $urandom_range(0, NUM_CHANNELS - 1);
                run = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 30) : 1;
            end
            if (chan_q[ch].size() == 0)
                plan_channel_traffic(ch);
            queue_byte(chan_q[ch].pop_front(), ch);
            if (chan_noise[ch] > 0)
                chan_noise[ch]--;
            else
                counted++;
            run--;
        end
        for (i = 0; i < NUM_CHANNELS; i++)
            while (chan_q[i].size() > 0)
                queue_byte(chan_q[i].pop_front(), i);
    endfunction

    task automatic send_items();
        int burst;
        int gap;
        burst = 0;
        while (stim_q.size() > 0)
        begin
            if (burst == 0)
            begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                      : $urandom_range(1, 24);
                gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            in_valid <= 1'b1;
            in_data  <= stim_q.pop_front();
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            burst--;
        end
        in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(logic [7:0] h, logic [7:0] e, logic [15:0] m);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] vals [4];
        int                    i;
        idx  = '{CFG_HEAD_MARKER, CFG_END_MARKER, CFG_MAX_USER_LENGTH, CFG_UNUSED};
        vals = '{{8'($urandom), h}, {8'($urandom), e}, m, 16'($urandom)};
        for (i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.write_reg(idx[i], vals[i]);
        end
        cfg_we   <= 1'b0;
        cur_head = h;
        cur_end  = e;
        cur_max  = int'(m);
    endtask

    task automatic run_random_phase(logic [7:0] h, logic [7:0] e, logic [15:0] m, int n_items);
        configure(h, e, m);
        mix_channel_traffic(n_items);
        send_items();
        wait_idle();
    endtask

    initial
    begin : stall_gen
        int mode;
        int seg;
        int tick;
        @(posedge rst_n);
        @(posedge clk);
        tick = 0;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (150) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(10, 150);
            while (seg > 0 && !hold_req)
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= ((tick % 5) < 2);
                endcase
                tick++;
                seg--;
                @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin : main_seq
        int i;
        logic [15:0] max_pick;
        sb = new();
        for (i = 0; i < NUM_CHANNELS; i++)
            chan_noise[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes outside a frame, empty payload, length out of range, checksum mismatch
        queue_byte(8'h00, 0);
        queue_byte(8'hFF, 7);
        build_frame(FR_GOOD, 8'hFF, 8'h00, 16'hFFFF, 16'd2);
        queue_frame(7);
        build_frame(FR_LEN_BAD, 8'h00, 8'hFF, 16'h0000, 16'd1);
        queue_frame(3);
        build_frame(FR_LEN_BAD, 8'h81, 8'h7E, 16'h0000, 16'd1025);
        queue_frame(4);
        build_frame(FR_SUM_BAD, 8'h00, 8'hFF, 16'h0000, 16'd2);
        queue_frame(1);
        // end marker changed in the middle of a frame
        build_frame(FR_GOOD, 8'h3C, 8'hC3, 16'h8001, 16'd3);
        for (i = 0; i < 7; i++)
            queue_byte(frame_buf[i], 2);
        send_items();
        wait_idle();
        configure(cur_head, 8'h3C, 16'(cur_max));
        for (i = 7; i < frame_buf.size(); i++)
            queue_byte(frame_buf[i], 2);
        send_items();
        wait_idle();

        hold_req = 1'b1;
        run_random_phase(HEAD_MARKER_RST, END_MARKER_RST, MAX_USER_LENGTH_RST, 400);
        run_random_phase(8'h00, 8'hFF, MIN_USER_LENGTH, 200);
        run_random_phase(8'hFF, 8'h00, 16'hFFFF, 250);
        for (i = 0; i < 3; i++)
        begin
            case (i)
                0: max_pick = 16'($urandom_range(2, 16));
                1: max_pick = 16'($urandom_range(17, 2000));
                default: max_pick = 16'($urandom_range(2000, 65535));
            endcase
            run_random_phase(8'($urandom), 8'($urandom), max_pick, 200);
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
